// ----- rtl/sns_pkg.sv -----
// ----------------------------------------------------------------------------
// Sequence number window package
// Shared constants, codes and types of the anti-replay window core.
// ----------------------------------------------------------------------------
package sns_pkg;

  localparam int SEQ_W      = 16;
  localparam int WIN_W      = 8;
  localparam int CNT_W      = 8;
  localparam int STAT_W     = 2;
  localparam int WINDOW_MAX = 256;
  localparam int IDX_W      = $clog2(WINDOW_MAX);
  localparam int CELL_W     = 16;
  localparam int SUB_W      = $clog2(CELL_W);
  localparam int N_CELLS    = WINDOW_MAX / CELL_W;
  localparam int CELL_IDX_W = IDX_W - SUB_W;
  localparam int PC_W       = SUB_W + 1;
  localparam int GRP_N      = 4;
  localparam int N_GRP      = N_CELLS / GRP_N;
  localparam int S1_W       = PC_W + 2;
  localparam int TOT_W      = S1_W + 2;

  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(32);

  typedef enum logic [STAT_W-1:0] {
    ST_NEW = 2'd0,
    ST_DUP = 2'd1,
    ST_OLD = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD  = 2'd0,
    OP_LOAD  = 2'd1,
    OP_SET   = 2'd2,
    OP_SHIFT = 2'd3
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [IDX_W-1:0] lag;
    logic [WIN_W-1:0] win;
  } cell_ctrl_t;

endpackage

// ----- rtl/sns_if.sv -----
// ----------------------------------------------------------------------------
// Sequence number window channels
// Valid/ready channels for input words, result words and the window register.
// ----------------------------------------------------------------------------
interface sns_in_if;
  logic                      valid;
  logic                      ready;
  logic [sns_pkg::SEQ_W-1:0] seq_num;

  modport source (output valid, output seq_num, input ready);
  modport sink (input valid, input seq_num, output ready);
endinterface

interface sns_out_if;
  logic                       valid;
  logic                       ready;
  logic [sns_pkg::STAT_W-1:0] status;
  logic [sns_pkg::SEQ_W-1:0]  newest;
  logic [sns_pkg::CNT_W-1:0]  held_count;

  modport source (output valid, output status, output newest, output held_count,
                  input ready);
  modport sink (input valid, input status, input newest, input held_count,
                output ready);
endinterface

interface sns_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [sns_pkg::WIN_W-1:0] win_len;

  modport source (output valid, output win_len, input ready);
  modport sink (input valid, input win_len, output ready);
endinterface

// ----- rtl/sns_cell.sv -----
// ----------------------------------------------------------------------------
// Sequence number window cell
// Holds one slice of the seen bitmap, updates it and counts its set bits.
// ----------------------------------------------------------------------------
module sns_cell (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               ld_i,
  input  logic [sns_pkg::CELL_IDX_W-1:0]     cell_idx_i,
  input  sns_pkg::cell_ctrl_t                ctrl_i,
  input  logic [sns_pkg::CELL_W-1:0]         shift_i,
  input  logic                               any_i,
  input  logic                               hit_i,
  output logic                               any_o,
  output logic                               hit_o,
  output logic [sns_pkg::CELL_W-1:0]         bits_o,
  output logic [sns_pkg::PC_W-1:0]           pc_o
);
  import sns_pkg::*;

  logic [CELL_W-1:0] bits_q, bits_d, keep, mark, seed;
  logic [PC_W-1:0]   pc_q, pc_d;
  logic              here;

  always_comb begin
    here = (ctrl_i.lag[IDX_W-1:SUB_W] == cell_idx_i);
    for (int j = 0; j < CELL_W; j++) begin
      keep[j] = ({cell_idx_i, SUB_W'(j)} < ctrl_i.win);
      mark[j] = here && (ctrl_i.lag[SUB_W-1:0] == SUB_W'(j));
    end
    seed = (cell_idx_i == '0) ? CELL_W'(1) : '0;
    unique case (ctrl_i.op)
      OP_HOLD:  bits_d = bits_q;
      OP_LOAD:  bits_d = seed;
      OP_SET:   bits_d = (bits_q | mark) & keep;
      OP_SHIFT: bits_d = (shift_i | seed) & keep;
      default:  bits_d = bits_q;
    endcase
    pc_d = PC_W'($countones(bits_d));
  end

  assign any_o  = any_i | (|bits_q);
  assign hit_o  = hit_i | (here && bits_q[ctrl_i.lag[SUB_W-1:0]]);
  assign bits_o = bits_q;
  assign pc_o   = pc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q <= '0;
    end else if (ld_i) begin
      bits_q <= bits_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      pc_q <= pc_d;
    end
  end

endmodule

// ----- rtl/seq_num_sliding_window_core.sv -----
// ----------------------------------------------------------------------------
// Sequence number sliding window core
// Anti-replay check of 16-bit serial sequence numbers over a row of bitmap cells.
// ----------------------------------------------------------------------------
// Channel   Direction  Word
// seq_i     in         seq_num
// res_o     out        status, newest, held_count
// cfg_i     in         win_len (always ready)
//
// One word is taken every cycle while seq_i is ready; the window state is
// updated at acceptance, so the next word is checked against it in the
// following cycle. Results pass through the s0, s1 and result registers
// while the cell counts are summed in a two-stage adder tree. Reset empties
// the bitmap at once and sets the window to 32. A stalled result stops the
// pipeline, and input ready falls only once every stage is full.
module seq_num_sliding_window_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  sns_in_if.sink     seq_i,
  sns_out_if.source  res_o,
  sns_cfg_if.sink    cfg_i
);
  import sns_pkg::*;

  logic [WIN_W-1:0]       win_q;
  logic [SEQ_W-1:0]       newest_q, newest_d;
  logic [WINDOW_MAX-1:0]  map_q, shifted;
  logic [SEQ_W-1:0]       lag, rel, jump;
  logic                   in_win, accept;
  logic [N_CELLS:0]       any_c, hit_c;
  logic [PC_W-1:0]        pc [N_CELLS];
  cell_ctrl_t             ctrl;
  op_e                    op;
  status_e                status;

  logic                   s0_v_q, s1_v_q, res_v_q;
  logic                   adv0, adv1, adv2;
  status_e                st0_q, st1_q, st2_q;
  logic [SEQ_W-1:0]       nw1_q, nw2_q;
  logic [S1_W-1:0]        sum1_q [N_GRP];
  logic [S1_W-1:0]        sum1_d [N_GRP];
  logic [TOT_W-1:0]       tot;
  logic [CNT_W-1:0]       cnt2_q;

  assign accept = seq_i.valid && seq_i.ready;
  assign cfg_i.ready = 1'b1;

  always_comb begin
    lag    = newest_q - seq_i.seq_num;
    rel    = lag - SEQ_W'(win_q);
    jump   = seq_i.seq_num - newest_q;
    in_win = (lag < SEQ_W'(win_q));
    priority if (!any_c[N_CELLS]) begin
      op = OP_LOAD;  status = ST_NEW;
    end else if (!rel[SEQ_W-1]) begin
      op = OP_HOLD;  status = ST_OLD;
    end else if (in_win && hit_c[N_CELLS]) begin
      op = OP_HOLD;  status = ST_DUP;
    end else if (in_win) begin
      op = OP_SET;   status = ST_NEW;
    end else begin
      op = OP_SHIFT; status = ST_NEW;
    end
    newest_d = ((op == OP_LOAD) || (op == OP_SHIFT)) ? seq_i.seq_num : newest_q;
    shifted  = (jump[SEQ_W-1:IDX_W] != '0) ? '0 : (map_q << jump[IDX_W-1:0]);
    ctrl.op   = op;
    ctrl.lag  = lag[IDX_W-1:0];
    ctrl.win  = win_q;
  end

  assign any_c[0] = 1'b0;
  assign hit_c[0] = 1'b0;

  for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
    sns_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ld_i       (accept),
      .cell_idx_i (CELL_IDX_W'(g)),
      .ctrl_i     (ctrl),
      .shift_i    (shifted[g*CELL_W +: CELL_W]),
      .any_i      (any_c[g]),
      .hit_i      (hit_c[g]),
      .any_o      (any_c[g+1]),
      .hit_o      (hit_c[g+1]),
      .bits_o     (map_q[g*CELL_W +: CELL_W]),
      .pc_o       (pc[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q    <= WIN_RESET;
      newest_q <= '0;
    end else begin
      if (cfg_i.valid) begin
        win_q <= cfg_i.win_len;
      end
      if (accept) begin
        newest_q <= newest_d;
      end
    end
  end

  assign adv2 = !res_v_q || res_o.ready;
  assign adv1 = !s1_v_q || adv2;
  assign adv0 = !s0_v_q || adv1;
  assign seq_i.ready = adv0;

  always_comb begin
    for (int g = 0; g < N_GRP; g++) begin
      sum1_d[g] = '0;
      for (int m = 0; m < GRP_N; m++) begin
        sum1_d[g] = sum1_d[g] + S1_W'(pc[g*GRP_N + m]);
      end
    end
    tot = '0;
    for (int g = 0; g < N_GRP; g++) begin
      tot = tot + TOT_W'(sum1_q[g]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q  <= 1'b0;
      s1_v_q  <= 1'b0;
      res_v_q <= 1'b0;
    end else begin
      if (adv0) begin
        s0_v_q <= accept;
      end
      if (adv1) begin
        s1_v_q <= s0_v_q;
      end
      if (adv2) begin
        res_v_q <= s1_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      st0_q <= status;
    end
    if (adv1 && s0_v_q) begin
      st1_q  <= st0_q;
      nw1_q  <= newest_q;
      sum1_q <= sum1_d;
    end
    if (adv2 && s1_v_q) begin
      st2_q  <= st1_q;
      nw2_q  <= nw1_q;
      cnt2_q <= tot[CNT_W-1:0];
    end
  end

  assign res_o.valid      = res_v_q;
  assign res_o.status     = st2_q;
  assign res_o.newest     = nw2_q;
  assign res_o.held_count = cnt2_q;

`ifndef SYNTHESIS
  a_load_fills : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (op == OP_LOAD) |=> any_c[N_CELLS])
    else $error("window still empty after a first word was stored");

  a_hold_keeps : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (op == OP_HOLD) |=> $stable(map_q) && $stable(newest_q))
    else $error("window state changed on a duplicate or stale word");

  a_shift_marks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (op == OP_SHIFT) && (win_q != '0) |=> map_q[0])
    else $error("newest sequence number not marked after a forward move");
`endif

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sequence number window core testbench
// Drives sequence number words into the anti-replay window core and checks
// every result word against a typed expected word or a behavioural model of
// the window. A directed table covers the edges of the window, wrap-around,
// large jumps and window sizes of 0, 1 and 255. Random phases follow, each
// with its own window size, under bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module tb_top;
  import sns_pkg::*;

  localparam int HOLD_CYCLES = 48;
  localparam int QUIET_LIMIT = 2000;
  localparam int N_PHASES    = 10;

  typedef struct packed {
    status_e          status;
    logic [SEQ_W-1:0] newest;
    logic [CNT_W-1:0] held;
  } verdict_t;

  typedef struct packed {
    logic             cfg;
    logic [SEQ_W-1:0] value;
    logic             typed;
    verdict_t         want;
  } plan_row_t;

  typedef enum int {RDY_ALWAYS, RDY_MOSTLY, RDY_SELDOM, RDY_PERIODIC} ready_mode_e;

  logic clk = 1'b0;
  logic rst_n;

  sns_in_if  seq_if ();
  sns_out_if res_if ();
  sns_cfg_if cfg_if ();

  seq_num_sliding_window_core dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .seq_i  (seq_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Model of the window: bit d of seen_map is set when top_seq - d is held.
  logic [WINDOW_MAX-1:0] seen_map;
  logic [SEQ_W-1:0]      top_seq;
  logic [CNT_W-1:0]      held_n;
  logic [WIN_W-1:0]      win_reg;

  verdict_t pending_verdicts [$];
  int       fail_count = 0;
  int       quiet_cycles = 0;
  bit       hold_req = 1'b0;

  // Rows are either a window write or a sequence number word; expected results
  // are typed in only where they are obvious, the model supplies the rest.
  plan_row_t plan [29] = '{
    '{1'b0, 16'h0000, 1'b1, '{ST_NEW, 16'h0000, 8'd1}},
    '{1'b0, 16'h0000, 1'b1, '{ST_DUP, 16'h0000, 8'd1}},
    '{1'b0, 16'h0005, 1'b0, '{ST_NEW, 16'h0000, 8'd0}},
    '{1'b0, 16'h0003, 1'b0, '{ST_NEW, 16'h0000, 8'd0}},
    '{1'b0, 16'hFFE5, 1'b1, '{ST_OLD, 16'h0005, 8'd3}},
    '{1'b0, 16'hFFE6, 1'b0, '{ST_NEW, 16'h0000, 8'd0}},
    '{1'b0, 16'h8005, 1'b1, '{ST_OLD, 16'h0005, 8'd4}},
    '{1'b0, 16'h8004, 1'b0, '{ST_NEW, 16'h0000, 8'd0}},
    '{1'b0, 16'h7FE5, 1'b1, '{ST_NEW, 16'h7FE5, 8'd1}},
    '{1'b0, 16'h7FE6, 1'b0, '{ST_NEW, 16'h0000, 8'd0}},
    '{1'b0, 16'hFFC0, 1'b1, '{ST_NEW, 16'hFFC0, 8'd1}},
    '{1'b0, 16'hFFF8, 1'b0, '{ST_NEW, 16'h0000, 8'd0}},
    '{1'b0, 16'h0003, 1'b0, '{ST_NEW, 16'h0000, 8'd0}},
    '{1'b0, 16'hFFFF, 1'b0, '{ST_NEW, 16'h0000, 8'd0}},
    '{1'b0, 16'hFFF8, 1'b0, '{ST_NEW, 16'h0000, 8'd0}},
    '{1'b1, 16'd1,    1'b0, '{ST_NEW, 16'h0000, 8'd0}},
    '{1'b0, 16'h0003, 1'b0, '{ST_NEW, 16'h0000, 8'd0}},
    '{1'b0, 16'h0002, 1'b1, '{ST_OLD, 16'h0003, 8'd3}},
    '{1'b0, 16'h0004, 1'b0, '{ST_NEW, 16'h0000, 8'd0}},
    '{1'b1, 16'd0,    1'b0, '{ST_NEW, 16'h0000, 8'd0}},
    '{1'b0, 16'h0004, 1'b1, '{ST_OLD, 16'h0004, 8'd1}},
    '{1'b0, 16'h0005, 1'b1, '{ST_NEW, 16'h0005, 8'd0}},
    '{1'b0, 16'h0100, 1'b1, '{ST_NEW, 16'h0100, 8'd1}},
    '{1'b0, 16'h0100, 1'b0, '{ST_NEW, 16'h0000, 8'd0}},
    '{1'b1, 16'd255,  1'b0, '{ST_NEW, 16'h0000, 8'd0}},
    '{1'b0, 16'h0001, 1'b1, '{ST_OLD, 16'h0100, 8'd1}},
    '{1'b0, 16'h0002, 1'b0, '{ST_NEW, 16'h0000, 8'd0}},
    '{1'b0, 16'h0180, 1'b1, '{ST_NEW, 16'h0180, 8'd2}},
    '{1'b1, 16'd32,   1'b0, '{ST_NEW, 16'h0000, 8'd0}}
  };

  function automatic void trim_map();
    seen_map &= (256'd1 << win_reg) - 256'd1;
    held_n = CNT_W'($countones(seen_map));
  endfunction

  function automatic verdict_t screen_seq(input logic [SEQ_W-1:0] seq);
    verdict_t         v;
    logic [SEQ_W-1:0] lag;
    logic [SEQ_W-1:0] rel;
    logic [SEQ_W-1:0] jump;
    v.status = ST_NEW;
    lag = top_seq - seq;
    rel = lag - SEQ_W'(win_reg);
    if (held_n == '0) begin
      seen_map = 256'd1;
      top_seq = seq;
      held_n = CNT_W'(1);
    end else if (rel < 16'h8000) begin
      v.status = ST_OLD;
    end else if (lag < SEQ_W'(win_reg)) begin
      if (seen_map[lag[IDX_W-1:0]]) begin
        v.status = ST_DUP;
      end else begin
        seen_map[lag[IDX_W-1:0]] = 1'b1;
        trim_map();
      end
    end else begin
      jump = seq - top_seq;
      seen_map = (seen_map << jump) | 256'd1;
      top_seq = seq;
      trim_map();
    end
    v.newest = top_seq;
    v.held = held_n;
    return v;
  endfunction

  function automatic logic [SEQ_W-1:0] pick_seq();
    int unsigned      r;
    logic [SEQ_W-1:0] span;
    r = $urandom_range(0, 99);
    span = SEQ_W'(win_reg);
    if (r < 40) return top_seq + SEQ_W'($urandom_range(1, 4));
    if (r < 45) return top_seq + SEQ_W'($urandom_range(5, 300));
    if (r < 85) return top_seq - SEQ_W'($urandom_range(0, win_reg + 2));
    if (r < 90) return top_seq + 16'h8000 - span + SEQ_W'($urandom_range(0, 4)) - 16'd2;
    return SEQ_W'($urandom());
  endfunction

  function automatic logic [WIN_W-1:0] pick_window(input int phase);
    if (phase == 0) return WIN_W'(255);
    if (phase == 1) return WIN_W'(1);
    case ($urandom_range(0, 7))
      0: return WIN_W'(1);
      1: return WIN_W'(255);
      2: return WIN_W'(0);
      3: return WIN_W'($urandom_range(2, 8));
      4: return WIN_RESET;
      default: return WIN_W'($urandom_range(1, 255));
    endcase
  endfunction

  task automatic put_seq(input logic [SEQ_W-1:0] seq, input logic typed,
                         input verdict_t given);
    verdict_t v;
    seq_if.valid <= 1'b1;
    seq_if.seq_num <= seq;
    do @(posedge clk); while (!(seq_if.valid && seq_if.ready));
    v = screen_seq(seq);
    pending_verdicts.push_back(typed ? given : v);
  endtask

  task automatic drain();
    seq_if.valid <= 1'b0;
    do @(posedge clk); while (pending_verdicts.size() != 0);
  endtask

  task automatic set_window(input logic [WIN_W-1:0] value);
    drain();
    cfg_if.valid <= 1'b1;
    cfg_if.win_len <= value;
    do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
    win_reg = value;
    cfg_if.valid <= 1'b0;
  endtask

  task automatic run_items(input int n, input bit steady);
    int left;
    int burst;
    int gap;
    left = n;
    while (left > 0) begin
      burst = steady ? left : int'($urandom_range(1, 12));
      if (burst > left) burst = left;
      repeat (burst) put_seq(pick_seq(), 1'b0, '0);
      left -= burst;
      gap = (steady || $urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 6));
      if (gap > 0) begin
        seq_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // The receiver changes its stall pattern after a random stretch and, when
  // asked, holds off long enough for the core to fill and stall its input.
  initial begin
    ready_mode_e ready_mode;
    int          stretch_left;
    ready_mode = RDY_ALWAYS;
    stretch_left = 0;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if (stretch_left == 0) begin
          ready_mode = ready_mode_e'($urandom_range(0, 3));
          stretch_left = $urandom_range(20, 80);
        end
        stretch_left--;
        case (ready_mode)
          RDY_ALWAYS: res_if.ready <= 1'b1;
          RDY_MOSTLY: res_if.ready <= ($urandom_range(0, 3) != 0);
          RDY_SELDOM: res_if.ready <= ($urandom_range(0, 3) == 0);
          default: res_if.ready <= ((stretch_left % 4) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result word, status %0d newest %h held %0d",
                 $time, res_if.status, res_if.newest, res_if.held_count);
        fail_count++;
      end else begin
        want = pending_verdicts.pop_front();
        if (res_if.status !== want.status) begin
          $display("%0t: status expected %0d, got %0d", $time, want.status, res_if.status);
          fail_count++;
        end
        if (res_if.newest !== want.newest) begin
          $display("%0t: newest expected %h, got %h", $time, want.newest, res_if.newest);
          fail_count++;
        end
        if (res_if.held_count !== want.held) begin
          $display("%0t: held_count expected %0d, got %0d", $time, want.held,
                   res_if.held_count);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((seq_if.valid && seq_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    int phase;
    rst_n = 1'b0;
    seq_if.valid = 1'b0;
    seq_if.seq_num = '0;
    cfg_if.valid = 1'b0;
    cfg_if.win_len = '0;
    seen_map = '0;
    top_seq = '0;
    held_n = '0;
    win_reg = WIN_RESET;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].cfg) begin
        set_window(plan[i].value[WIN_W-1:0]);
      end else begin
        put_seq(plan[i].value, plan[i].typed, plan[i].want);
      end
    end

    for (phase = 0; phase < N_PHASES; phase++) begin
      set_window(pick_window(phase));
      if (phase == 2) begin
        hold_req = 1'b1;
        run_items(40, 1'b1);
      end else begin
        run_items($urandom_range(30, 60), 1'b0);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
